// ----- hw/rtl/plcm_pkg.sv -----
// plcm_pkg: shared types, constants and codes for the piecewise linear colormap.
// No dependencies.
package plcm_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [2:0] {
    REQ_APPEND = 3'd0,
    REQ_CLEAR  = 3'd1,
    REQ_MAP    = 3'd2,
    REQ_SCALE  = 3'd3,
    REQ_SETMIN = 3'd4,
    REQ_SETMAX = 3'd5
  } req_t;

  localparam logic CFG_AUTO_UPDATE = 1'b0;
  localparam logic CFG_AUTO_SCALE  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MRD0,
    ST_MCHK0,
    ST_MCHKL,
    ST_MSRCH,
    ST_MRDJ1,
    ST_MDIV,
    ST_MBLEND,
    ST_SDIV,
    ST_SWR,
    ST_OUT
  } state_t;

  function automatic logic [7:0] blend_chan(input logic [7:0] a, input logic [7:0] b,
                                            input logic [8:0] f);
    logic [17:0] s;
    s = 18'(a) * 18'(9'd256 - f) + 18'(b) * 18'(f);
    return s[15:8];
  endfunction

endpackage

// ----- hw/rtl/piecewise_linear_colormap_top.sv -----
// piecewise_linear_colormap_top: breakpoint/colour table in a synchronous memory,
// sequencer for map and autoscale requests, restoring divider. Uses plcm_pkg.
//
// Usage:
//  - Input channel (in_valid/in_stall) carries one request beat: req_type, value
//    and the appended colour. Output channel (out_valid/out_stall) returns exactly
//    one result beat per request.
//  - Config writes (cfg_we/cfg_index/cfg_data) only while the block is idle.
//  - One request is processed at a time; in_stall is high during reset, while busy
//    or while a result is held. Append/clear/set/unknown requests, a map with an
//    empty table and an autoscale that is disabled or has an empty table give the
//    result beat the cycle after acceptance.
//    Map: checks the first entry, then the last, for clamping; otherwise walks back
//    through the table one read at a time, reads the next entry, divides and
//    blends. A flat or descending segment skips the divider.
//    Autoscale: one serial 32-bit division and one write per entry.
//    The memory read port reads one entry per cycle; the divider is bit-serial.
//  - Reset (rst, sync) empties the table, zeros min/max, enables both auto
//    modes. Memory contents are not cleared; only entries below the count are read.
//  - When the receiver stalls, the result beat holds and no new request enters.
module piecewise_linear_colormap_top
  import plcm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  req_type,
  input  logic signed [15:0] value,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic        table_empty,
  output logic        append_refused,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic        cfg_data
);

  // table memory: {breakpoint, colour}
  logic [39:0] mem [TABLE_DEPTH];
  logic [39:0] rd_data;
  logic [IDX_W-1:0] rd_addr, wr_addr;
  logic [39:0] wr_data;
  logic wr_en;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  logic signed [15:0] rd_bp;
  assign rd_bp = rd_data[39:24];

  state_t state, state_next;
  logic [CNT_W-1:0] count;
  logic signed [15:0] tmin, tmax;
  logic auto_upd, auto_scl;
  logic signed [15:0] val;
  logic [IDX_W-1:0] j;
  logic [CNT_W-1:0] i;
  logic signed [15:0] bp_j;
  logic [23:0] col_j, col_j1;
  logic [23:0] res_col;
  logic res_empty, res_ref;

  // serial divider: unsigned 32/32
  logic [31:0] dnum, dden, dq;
  logic [32:0] drem;
  logic [5:0] dcnt;
  logic dneg;
  logic [32:0] dtrial;
  assign dtrial = {drem[31:0], dnum[31]} - {1'b0, dden};

  logic accept_in;
  assign accept_in = in_valid && !in_stall;
  assign in_stall = rst || (state != ST_IDLE);
  assign out_valid = (state == ST_OUT);
  assign out_red = res_col[23:16];
  assign out_green = res_col[15:8];
  assign out_blue = res_col[7:0];
  assign table_empty = res_empty;
  assign append_refused = res_ref;

  // signed helpers
  logic signed [16:0] seg_d;
  logic signed [16:0] off;
  logic signed [31:0] span;
  logic signed [31:0] quo_s;
  logic [8:0] frac;
  assign seg_d = 17'(rd_bp) - 17'(bp_j);
  assign off = 17'(val) - 17'(bp_j);
  assign span = 32'(tmax) - 32'(tmin);
  assign quo_s = dneg ? -$signed(dq) : $signed(dq);
  always_comb begin
    if (quo_s < 0) frac = 9'd0;
    else if (quo_s > 256) frac = 9'd256;
    else frac = quo_s[8:0];
  end

  logic [CNT_W-1:0] last;
  assign last = count - CNT_W'(1);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept_in) begin
          case (req_type)
            REQ_MAP:   state_next = (count == '0) ? ST_OUT : ST_MRD0;
            REQ_SCALE: state_next = (auto_scl && count != '0) ? ST_SDIV : ST_OUT;
            default:   state_next = ST_OUT;
          endcase
        end
      end
      ST_MRD0:  state_next = ST_MCHK0;
      ST_MCHK0: state_next = (count == CNT_W'(1) || val <= rd_bp) ? ST_OUT : ST_MCHKL;
      ST_MCHKL: state_next = (val >= rd_bp) ? ST_OUT : ST_MSRCH;
      ST_MSRCH: state_next = (j == '0 || val >= rd_bp) ? ST_MRDJ1 : ST_MSRCH;
      ST_MRDJ1: state_next = (seg_d <= 0) ? ST_MBLEND : ST_MDIV;
      ST_MDIV:  state_next = (dcnt == '0) ? ST_MBLEND : ST_MDIV;
      ST_MBLEND: state_next = ST_OUT;
      ST_SDIV:  state_next = (dcnt == '0) ? ST_SWR : ST_SDIV;
      ST_SWR:   state_next = (i == last) ? ST_OUT : ST_SDIV;
      ST_OUT:   state_next = out_stall ? ST_OUT : ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // memory port control
  always_comb begin
    rd_addr = j;
    wr_en = 1'b0;
    wr_addr = count[IDX_W-1:0];
    wr_data = {value, in_red, in_green, in_blue};
    case (state)
      ST_IDLE: begin
        rd_addr = '0;
        wr_en = accept_in && req_type == REQ_APPEND && count < CNT_W'(TABLE_DEPTH);
      end
      ST_MCHK0: rd_addr = last[IDX_W-1:0];
      ST_MCHKL: rd_addr = j;
      ST_MSRCH: rd_addr = (j == '0 || val >= rd_bp) ? IDX_W'(j + 1'b1) : IDX_W'(j - 1'b1);
      ST_SWR: begin
        rd_addr = i[IDX_W-1:0];
        wr_en = 1'b1;
        wr_addr = i[IDX_W-1:0];
        wr_data = {16'(32'(tmin) + quo_s), rd_data[23:0]};
      end
      ST_SDIV: rd_addr = i[IDX_W-1:0];
      default: rd_addr = j;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      tmin <= '0;
      tmax <= '0;
      auto_upd <= 1'b1;
      auto_scl <= 1'b1;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        if (cfg_index == CFG_AUTO_UPDATE) auto_upd <= cfg_data;
        else auto_scl <= cfg_data;
      end
      if (accept_in) begin
        case (req_type)
          REQ_APPEND: if (count < CNT_W'(TABLE_DEPTH)) count <= count + CNT_W'(1);
          REQ_CLEAR:  count <= '0;
          REQ_MAP: if (auto_upd) begin
            if (value < tmin) tmin <= value;
            if (value > tmax) tmax <= value;
          end
          REQ_SETMIN: tmin <= value;
          REQ_SETMAX: tmax <= value;
          default: ;
        endcase
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: if (accept_in) begin
        val <= value;
        res_col <= '0;
        res_empty <= (req_type == REQ_MAP) && (count == '0);
        res_ref <= (req_type == REQ_APPEND) && (count == CNT_W'(TABLE_DEPTH));
        i <= '0;
        j <= '0;
        if (req_type == REQ_SCALE) begin
          // first quotient: 0 * span / (n-1) = 0; with one entry divisor forced 1
          dnum <= '0;
          dden <= 32'd1;
          drem <= '0;
          dneg <= 1'b0;
          dcnt <= 6'd32;
        end
      end
      ST_MCHK0: begin
        if (count == CNT_W'(1) || val <= rd_bp) res_col <= rd_data[23:0];
        j <= IDX_W'(count - CNT_W'(2));
      end
      ST_MCHKL: if (val >= rd_bp) res_col <= rd_data[23:0];
      ST_MSRCH: if (j == '0 || val >= rd_bp) begin
        bp_j <= rd_bp;
        col_j <= rd_data[23:0];
      end else j <= j - 1'b1;
      ST_MRDJ1: begin
        col_j1 <= rd_data[23:0];
        // off >= 0 here; quotient = off*256/seg_d
        dnum <= {7'd0, off[16:0], 8'd0};
        dden <= {15'd0, seg_d};
        drem <= '0;
        dneg <= 1'b0;
        dcnt <= 6'd32;
        if (seg_d <= 0) dq <= 32'd256;
      end
      ST_MDIV, ST_SDIV: if (dcnt != '0) begin
        if (!dtrial[32]) begin
          drem <= dtrial;
          dq <= {dq[30:0], 1'b1};
        end else begin
          drem <= {drem[31:0], dnum[31]};
          dq <= {dq[30:0], 1'b0};
        end
        dnum <= {dnum[30:0], 1'b0};
        dcnt <= dcnt - 6'd1;
      end
      ST_MBLEND: res_col <= {blend_chan(col_j[23:16], col_j1[23:16], frac),
                             blend_chan(col_j[15:8], col_j1[15:8], frac),
                             blend_chan(col_j[7:0], col_j1[7:0], frac)};
      ST_SWR: begin
        // set up next entry: (i+1)*span/(n-1), truncated toward zero
        i <= i + CNT_W'(1);
        dneg <= span[31];
        dnum <= (span[31] ? 32'(-span) : 32'(span)) * 32'(i + CNT_W'(1));
        dden <= 32'(last);
        drem <= '0;
        dq <= '0;
        dcnt <= 6'd32;
      end
      default: ;
    endcase
    if (state == ST_IDLE && accept_in) dq <= '0;
  end

  // checks
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(TABLE_DEPTH)) else $error("count overflow");
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("accepted while result pending");
  a_empty_black: assert property (@(posedge clk) disable iff (rst)
    (out_valid && table_empty) |-> res_col == '0) else $error("empty map not black");
  a_refuse_full: assert property (@(posedge clk) disable iff (rst)
    (out_valid && append_refused) |-> count == CNT_W'(TABLE_DEPTH))
    else $error("refused while not full");

endmodule

// ----- tb/sv/piecewise_linear_colormap_top_test.sv -----
// Self-checking testbench for piecewise_linear_colormap_top: drives request beats with
// random gaps and stalls, predicts every result from its own colormap model.
// Depends on plcm_pkg and the piecewise_linear_colormap_top RTL.
module piecewise_linear_colormap_top_test
  import plcm_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_WAIT = 13;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       empty;
    logic       refused;
  } color_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] req_type = '0;
  logic signed [15:0] value = '0;
  logic [7:0] in_red = '0, in_green = '0, in_blue = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  logic [7:0] out_red, out_green, out_blue;
  logic table_empty, append_refused;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic cfg_data = 1'b0;

  piecewise_linear_colormap_top DUT (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow copy of the colormap state
  logic signed [15:0] bp_shadow [TABLE_DEPTH];
  logic [23:0]        rgb_shadow [TABLE_DEPTH];
  int                 count_shadow;
  logic signed [15:0] min_shadow, max_shadow;
  logic               auto_update_on, auto_scale_on;

  color_result_t expected_colors[$];
  int errors = 0;
  int beats_sent = 0;
  int maps_sent = 0;
  int results_seen = 0;

  function automatic logic [7:0] mix_channel(logic [7:0] a, logic [7:0] b, int frac);
    int s;
    s = int'(a) * (256 - frac) + int'(b) * frac;
    return 8'(s >>> 8);
  endfunction

  function automatic logic [23:0] lookup_color(logic signed [15:0] v);
    int j;
    longint d, q;
    int frac;
    logic [23:0] c0, c1;
    if (count_shadow == 1 || v <= bp_shadow[0]) return rgb_shadow[0];
    if (v >= bp_shadow[count_shadow-1]) return rgb_shadow[count_shadow-1];
    j = count_shadow - 2;
    while (j > 0 && v < bp_shadow[j]) j--;
    d = longint'(bp_shadow[j+1]) - longint'(bp_shadow[j]);
    if (d <= 0) frac = 256;
    else begin
      q = (longint'(v) - longint'(bp_shadow[j])) * 256 / d;
      if (q < 0) q = 0;
      if (q > 256) q = 256;
      frac = int'(q);
    end
    c0 = rgb_shadow[j];
    c1 = rgb_shadow[j+1];
    return {mix_channel(c0[23:16], c1[23:16], frac), mix_channel(c0[15:8], c1[15:8], frac),
            mix_channel(c0[7:0], c1[7:0], frac)};
  endfunction

  // Advances the shadow state by one request and returns its result
  function automatic color_result_t predict_color(logic [2:0] rq, logic signed [15:0] v,
                                                  logic [23:0] rgb);
    color_result_t r;
    longint span;
    r = '0;
    case (rq)
      REQ_APPEND: begin
        if (count_shadow < TABLE_DEPTH) begin
          bp_shadow[count_shadow] = v;
          rgb_shadow[count_shadow] = rgb;
          count_shadow++;
        end else r.refused = 1'b1;
      end
      REQ_CLEAR: count_shadow = 0;
      REQ_MAP: begin
        if (auto_update_on) begin
          if (v < min_shadow) min_shadow = v;
          if (v > max_shadow) max_shadow = v;
        end
        if (count_shadow == 0) r.empty = 1'b1;
        else {r.red, r.green, r.blue} = lookup_color(v);
      end
      REQ_SCALE: begin
        if (auto_scale_on && count_shadow == 1) bp_shadow[0] = min_shadow;
        else if (auto_scale_on && count_shadow > 1) begin
          span = longint'(max_shadow) - longint'(min_shadow);
          for (int i = 0; i < count_shadow; i++)
            bp_shadow[i] = 16'(longint'(min_shadow) + (longint'(i) * span) / (count_shadow - 1));
        end
      end
      REQ_SETMIN: min_shadow = v;
      REQ_SETMAX: max_shadow = v;
      default: ;
    endcase
    return r;
  endfunction

  // Sends one request beat after a random gap; prediction is made on acceptance.
  // Valid stays high after acceptance until the next gap or a drain drops it.
  task automatic send_request(logic [2:0] rq, logic signed [15:0] v, logic [23:0] rgb);
    int w;
    w = $urandom_range(0, MAX_WAIT);
    if (w != 0) begin
      in_valid <= 1'b0;
      repeat (w) @(posedge clk);
    end
    req_type <= rq;
    value <= v;
    {in_red, in_green, in_blue} <= rgb;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_colors.insert(expected_colors.size(), predict_color(rq, v, rgb));
    beats_sent++;
    if (rq == REQ_MAP) maps_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_colors.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_config(logic idx, logic data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_AUTO_UPDATE) auto_update_on = data;
    else auto_scale_on = data;
    @(posedge clk);
  endtask

  // Receiver: random stall per beat, compares each accepted result
  initial begin : result_checker
    color_result_t exp_r;
    int w;
    forever begin
      w = $urandom_range(0, MAX_WAIT);
      if ($urandom_range(0, 3) == 0) w = 0;
      if (w != 0) begin
        out_stall <= 1'b1;
        repeat (w) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
      results_seen++;
      if (expected_colors.size() == 0) begin
        $error("result beat with no request pending");
        errors++;
      end else begin
        exp_r = expected_colors.pop_front();
        if (out_red !== exp_r.red) begin
          $error("out_red expected %0d got %0d", exp_r.red, out_red); errors++;
        end
        if (out_green !== exp_r.green) begin
          $error("out_green expected %0d got %0d", exp_r.green, out_green); errors++;
        end
        if (out_blue !== exp_r.blue) begin
          $error("out_blue expected %0d got %0d", exp_r.blue, out_blue); errors++;
        end
        if (table_empty !== exp_r.empty) begin
          $error("table_empty expected %0d got %0d", exp_r.empty, table_empty); errors++;
        end
        if (append_refused !== exp_r.refused) begin
          $error("append_refused expected %0d got %0d", exp_r.refused, append_refused);
          errors++;
        end
      end
    end
  end

  function automatic logic signed [15:0] rand_value();
    case ($urandom_range(0, 5))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'(signed'($urandom_range(0, 400)) - 200);
      default: return 16'($urandom);
    endcase
  endfunction

  // Directed: empty table, single entry, extremes, flat and descending segments,
  // overflow, unknown codes, autoscale corner cases.
  task automatic test_directed();
    send_request(REQ_MAP, 16'sd5, 24'h0);
    send_request(REQ_SCALE, 16'sd0, 24'h0);
    send_request(REQ_APPEND, 16'sh8000, 24'hffffff);
    send_request(REQ_MAP, 16'sh7fff, 24'h0);
    send_request(REQ_SCALE, 16'sd0, 24'h0);
    send_request(REQ_APPEND, 16'sh7fff, 24'h000000);
    send_request(REQ_MAP, 16'sd0, 24'h0);
    send_request(REQ_APPEND, 16'sd100, 24'h123456);
    send_request(REQ_APPEND, 16'sd100, 24'hff00aa);
    send_request(REQ_MAP, 16'sh7ffe, 24'h0);
    send_request(REQ_MAP, 16'sh8000, 24'h0);
    for (int i = 0; i < 13; i++) send_request(REQ_APPEND, 16'(i * 7), 24'($urandom));
    send_request(REQ_APPEND, 16'sd9, 24'haaaaaa);
    send_request(3'd6, 16'sh7fff, 24'hffffff);
    send_request(3'd7, 16'sh8000, 24'hffffff);
    send_request(REQ_SETMIN, 16'sd500, 24'h0);
    send_request(REQ_SETMAX, 16'sh8000, 24'h0);
    send_request(REQ_SCALE, 16'sd0, 24'h0);
    send_request(REQ_MAP, 16'sd0, 24'h0);
    send_request(REQ_CLEAR, 16'sd0, 24'h0);
    send_request(REQ_MAP, 16'sd1, 24'h0);
  endtask

  // Random: mostly build a table then map into it, with occasional other requests
  task automatic test_random(int n);
    int k, sent;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(0, 9) == 0) send_request(REQ_CLEAR, rand_value(), 24'($urandom));
      k = $urandom_range(1, 18);
      for (int i = 0; i < k; i++)
        send_request(REQ_APPEND, ($urandom_range(0, 1) ? 16'($urandom) :
                     16'(i * $urandom_range(1, 3000) - 20000)), 24'($urandom));
      for (int i = 0; i < 20; i++) begin
        case ($urandom_range(0, 15))
          0: send_request(REQ_SCALE, rand_value(), 24'($urandom));
          1: send_request(REQ_SETMIN, rand_value(), 24'($urandom));
          2: send_request(REQ_SETMAX, rand_value(), 24'($urandom));
          3: send_request(3'($urandom_range(6, 7)), rand_value(), 24'($urandom));
          4: send_request(REQ_APPEND, rand_value(), 24'($urandom));
          default: send_request(REQ_MAP, rand_value(), 24'($urandom));
        endcase
      end
      sent += k + 21;
    end
  endtask

  initial begin : run_limit
    #20000000;
    $display("piecewise_linear_colormap_top verification failed");
    $finish;
  end

  initial begin : stimulus
    count_shadow = 0;
    min_shadow = 0;
    max_shadow = 0;
    auto_update_on = 1'b1;
    auto_scale_on = 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    wait_drained(); // sender holds off until the pipe is empty
    test_random(450);
    wait_drained();
    write_config(CFG_AUTO_UPDATE, 1'b0);
    write_config(CFG_AUTO_SCALE, 1'b0);
    test_random(450);
    wait_drained();
    write_config(CFG_AUTO_UPDATE, 1'b1);
    test_random(450);
    wait_drained();
    write_config(CFG_AUTO_UPDATE, 1'b0);
    write_config(CFG_AUTO_SCALE, 1'b1);
    test_random(450);
    wait_drained();
    $display("Sent %0d request beats (%0d maps), checked %0d results over four config settings.",
             beats_sent, maps_sent, results_seen);
    if (errors == 0) $display("piecewise_linear_colormap_top verification clean");
    else $display("piecewise_linear_colormap_top verification failed");
    $finish;
  end

endmodule
